// File: hdl/rrts_pkg.sv
// Package with the types, constants and helpers shared by the task scheduler files.
`default_nettype none

package rrts_pkg;

    // Table sizes.
    localparam int TASK_SLOTS  = 16;
    localparam int SLEEP_SLOTS = 8;
    localparam int IDX_W       = $clog2(TASK_SLOTS);
    localparam int CNT_W       = $clog2(SLEEP_SLOTS + 1);

    // Request kinds.
    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_TICK    = 3'd1;
    localparam logic [2:0] REQ_CREATE  = 3'd2;
    localparam logic [2:0] REQ_BLOCK   = 3'd3;
    localparam logic [2:0] REQ_UNBLOCK = 3'd4;
    localparam logic [2:0] REQ_SLEEP   = 3'd5;
    localparam logic [2:0] REQ_WAKE    = 3'd6;

    // Status codes.
    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_TABLE_FULL = 3'd1;
    localparam logic [2:0] STS_SLEEP_FULL = 3'd2;
    localparam logic [2:0] STS_BAD_INDEX  = 3'd3;
    localparam logic [2:0] STS_EXPIRED    = 3'd4;
    localparam logic [2:0] STS_NO_READY   = 3'd5;

    // Task states.
    localparam logic [1:0] TS_UNUSED  = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_RUNNING = 2'd2;
    localparam logic [1:0] TS_PAUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NORMAL_SLICE  = 2'd0;
    localparam logic [1:0] CFG_IDLE_PRIORITY = 2'd1;
    localparam logic [1:0] CFG_IDLE_SLICE    = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  task_index;
        logic [7:0]  priority_req;
        logic [31:0] now_ms;
        logic [31:0] expiry_ms;
    } req_t;

    typedef struct packed {
        logic [3:0] running_index;
        logic       switched;
        logic [3:0] new_index;
        logic [2:0] status;
    } rsp_t;

    typedef struct packed {
        logic [7:0] normal_slice;
        logic [7:0] idle_priority;
        logic [7:0] idle_slice;
    } cfg_t;

    // One task table entry.
    typedef struct packed {
        logic [1:0]  state;
        logic [7:0]  prio;
        logic        sleeping;
        logic [31:0] wake;
    } entry_t;

    // Memory port request from the controller.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    // Contents of an entry that has not been written since reset.
    function automatic entry_t entry_reset(input logic [IDX_W-1:0] addr);
        entry_t e;
        e = '0;
        if (addr == '0)
        begin
            e.state = TS_RUNNING;
            e.prio  = 8'd1;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: hdl/rrts_mem.sv
// Task table memory with a registered read port and per-entry written marks.
`default_nettype none

module rrts_mem
    import rrts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t mreq,
    output entry_t        rd_data
);

    entry_t                  mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   vld_reg;
    entry_t                  rd_q_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_addr_reg;

    // Storage array: write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        if (mreq.rd_en)
        begin
            rd_q_reg <= mem[mreq.rd_addr];
        end
    end

    // Written marks, cleared at once by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (mreq.wr_en)
            begin
                vld_reg[mreq.wr_addr] <= 1'b1;
            end
            if (mreq.rd_en)
            begin
                rd_vld_reg  <= vld_reg[mreq.rd_addr];
                rd_addr_reg <= mreq.rd_addr;
            end
        end
    end

    // An entry never written reads as its reset contents.
    assign rd_data = rd_vld_reg ? rd_q_reg : entry_reset(rd_addr_reg);

endmodule

`default_nettype wire

// File: hdl/rrts_ctrl.sv
// Request sequencer: reads, modifies and writes back task entries and builds each result.
`default_nettype none

module rrts_ctrl
    import rrts_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire req_t   in_data,
    output logic        out_valid,
    input  wire logic   out_stall,
    output rsp_t        out_data,
    output mem_req_t    mreq,
    input  wire entry_t rd_data
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Entry operations.
    localparam logic [2:0] OP_BLOCK   = 3'd0;
    localparam logic [2:0] OP_UNBLOCK = 3'd1;
    localparam logic [2:0] OP_SLEEP   = 3'd2;
    localparam logic [2:0] OP_WAKE    = 3'd3;
    localparam logic [2:0] OP_RSCUR   = 3'd4;
    localparam logic [2:0] OP_SCAN    = 3'd5;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    req_t             req_reg, req_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0] sleepers_reg, sleepers_next;
    logic [7:0]       slice_reg, slice_next;
    logic             enabled_reg, enabled_next;
    logic             switched_reg, switched_next;
    logic [IDX_W-1:0] new_idx_reg, new_idx_next;
    logic [2:0]       status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_data_reg, out_data_next;
    entry_t           wr_e;
    logic             accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Round-robin successor within the entries in use.
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] last);
        return (x == last) ? '0 : x + 1'b1;
    endfunction

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        sleepers_next  = sleepers_reg;
        slice_next     = slice_reg;
        enabled_next   = enabled_reg;
        switched_next  = switched_reg;
        new_idx_next   = new_idx_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mreq           = '0;
        wr_e           = rd_data;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = in_data;
                    switched_next = 1'b0;
                    new_idx_next  = '0;
                    status_next   = STS_OK;
                    state_next    = S_DONE;
                    case (in_data.req_type)
                        REQ_START:
                        begin
                            enabled_next = 1'b1;
                        end
                        REQ_TICK:
                        begin
                            if (enabled_reg)
                            begin
                                slice_next = slice_reg - 8'd1;
                                if (slice_reg == 8'd1)
                                begin
                                    op_next    = OP_RSCUR;
                                    addr_next  = cur_reg;
                                    state_next = S_RD;
                                end
                            end
                        end
                        REQ_CREATE:
                        begin
                            if (last_reg == IDX_W'(TASK_SLOTS - 1))
                            begin
                                status_next = STS_TABLE_FULL;
                            end
                            else
                            begin
                                mreq.wr_en         = 1'b1;
                                mreq.wr_addr       = last_reg + 1'b1;
                                mreq.wr_data       = '0;
                                mreq.wr_data.state = TS_READY;
                                mreq.wr_data.prio  = in_data.priority_req;
                                last_next          = last_reg + 1'b1;
                                new_idx_next       = last_reg + 1'b1;
                            end
                        end
                        REQ_BLOCK:
                        begin
                            op_next    = OP_BLOCK;
                            addr_next  = cur_reg;
                            state_next = S_RD;
                        end
                        REQ_UNBLOCK:
                        begin
                            if (in_data.task_index > 4'(last_reg))
                            begin
                                status_next = STS_BAD_INDEX;
                            end
                            else
                            begin
                                op_next    = OP_UNBLOCK;
                                addr_next  = IDX_W'(in_data.task_index);
                                state_next = S_RD;
                            end
                        end
                        REQ_SLEEP:
                        begin
                            if (in_data.expiry_ms < in_data.now_ms)
                            begin
                                status_next = STS_EXPIRED;
                            end
                            else
                            begin
                                op_next    = OP_SLEEP;
                                addr_next  = cur_reg;
                                state_next = S_RD;
                            end
                        end
                        REQ_WAKE:
                        begin
                            op_next    = OP_WAKE;
                            addr_next  = '0;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = addr_reg;
                state_next   = S_EV;
            end

            S_EV:
            begin
                mreq.wr_addr = addr_reg;
                state_next   = S_DONE;
                case (op_reg)
                    OP_BLOCK:
                    begin
                        wr_e.state   = TS_PAUSED;
                        mreq.wr_en   = 1'b1;
                        op_next      = OP_SCAN;
                        addr_next    = next_idx(cur_reg, last_reg);
                        cnt_next     = '0;
                        state_next   = S_RD;
                    end
                    OP_UNBLOCK:
                    begin
                        wr_e.state = TS_READY;
                        mreq.wr_en = 1'b1;
                    end
                    OP_SLEEP:
                    begin
                        if (!rd_data.sleeping && sleepers_reg >= CNT_W'(SLEEP_SLOTS))
                        begin
                            status_next = STS_SLEEP_FULL;
                        end
                        else
                        begin
                            if (!rd_data.sleeping)
                            begin
                                sleepers_next = sleepers_reg + 1'b1;
                            end
                            wr_e.state    = TS_PAUSED;
                            wr_e.sleeping = 1'b1;
                            wr_e.wake     = req_reg.expiry_ms;
                            mreq.wr_en    = 1'b1;
                            op_next       = OP_SCAN;
                            addr_next     = next_idx(cur_reg, last_reg);
                            cnt_next      = '0;
                            state_next    = S_RD;
                        end
                    end
                    OP_WAKE:
                    begin
                        if (rd_data.sleeping && rd_data.state == TS_PAUSED &&
                            rd_data.wake < req_reg.now_ms)
                        begin
                            wr_e.state    = TS_READY;
                            wr_e.sleeping = 1'b0;
                            mreq.wr_en    = 1'b1;
                            if (sleepers_reg != '0)
                            begin
                                sleepers_next = sleepers_reg - 1'b1;
                            end
                        end
                        if (addr_reg == last_reg)
                        begin
                            op_next   = OP_RSCUR;
                            addr_next = cur_reg;
                        end
                        else
                        begin
                            addr_next = addr_reg + 1'b1;
                        end
                        state_next = S_RD;
                    end
                    OP_RSCUR:
                    begin
                        // The running task drops back to ready before the search.
                        if (rd_data.state == TS_RUNNING)
                        begin
                            wr_e.state = TS_READY;
                            mreq.wr_en = 1'b1;
                        end
                        op_next    = OP_SCAN;
                        addr_next  = next_idx(cur_reg, last_reg);
                        cnt_next   = '0;
                        state_next = S_RD;
                    end
                    OP_SCAN:
                    begin
                        if (rd_data.state == TS_READY)
                        begin
                            wr_e.state    = TS_RUNNING;
                            mreq.wr_en    = 1'b1;
                            cur_next      = addr_reg;
                            switched_next = 1'b1;
                            slice_next    = (rd_data.prio == cfg.idle_priority) ?
                                            cfg.idle_slice : cfg.normal_slice;
                        end
                        else if (cnt_reg == last_reg)
                        begin
                            status_next = STS_NO_READY;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 1'b1;
                            addr_next  = next_idx(addr_reg, last_reg);
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
                mreq.wr_data = wr_e;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.running_index  = 4'(cur_reg);
                    out_data_next.switched       = switched_reg;
                    out_data_next.new_index      = 4'(new_idx_reg);
                    out_data_next.status         = status_reg;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_BLOCK;
            req_reg       <= '0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            last_reg      <= '0;
            sleepers_reg  <= '0;
            slice_reg     <= '0;
            enabled_reg   <= 1'b0;
            switched_reg  <= 1'b0;
            new_idx_reg   <= '0;
            status_reg    <= STS_OK;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            req_reg       <= req_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            sleepers_reg  <= sleepers_next;
            slice_reg     <= slice_next;
            enabled_reg   <= enabled_next;
            switched_reg  <= switched_next;
            new_idx_reg   <= new_idx_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/round_robin_task_scheduler.sv
// Round-robin task scheduler: top level with configuration registers.
//
// Requests enter on in_valid/in_stall with an in_data payload; one result per
// request leaves on out_valid/out_stall with out_data. A request is taken when
// valid is high and stall is low. Configuration writes use cfg_valid/cfg_ready
// (ready is always high); the user must make them only while no request is in
// flight, and the block itself does not enforce it. The task table sits in one
// synchronous memory; each entry touched passes a read step and an
// evaluate/write-back step. Start, create, bad index, expired sleep, an
// unknown kind and a tick that does not reschedule need no read; unblock and
// a full sleep list read one entry; block, sleep and a rescheduling tick first
// update the current entry, then search from the next one in use (up to last
// entry + 1 entries); wake scans the entries in use, then reschedules too.
// One request is worked on at a time; a new request is taken once the previous
// result is in the output register.
// If the receiver stalls, the result waits in the output register and the
// block holds the next finished request until the register frees.
// Reset is asynchronous: entry 0 is running with priority 1, all other entries
// unused, the scheduler disabled, and the registers back to 5, 255 and 1.
`default_nettype none

module round_robin_task_scheduler
    import rrts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire req_t       in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output rsp_t            out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    mem_req_t mreq;
    entry_t   rd_data;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NORMAL_SLICE:  cfg_next.normal_slice  = cfg_data;
                CFG_IDLE_PRIORITY: cfg_next.idle_priority = cfg_data;
                CFG_IDLE_SLICE:    cfg_next.idle_slice    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_slice  <= 8'd5;
            cfg_reg.idle_priority <= 8'd255;
            cfg_reg.idle_slice    <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Request sequencer.
    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .mreq      (mreq),
        .rd_data   (rd_data)
    );

    // Task table.
    rrts_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// File: hdl/rrts_checker.sv
// Port-level checks for the task scheduler and their binding to the top level.
`default_nettype none

module rrts_checker
    import rrts_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire rsp_t       out_data
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken without going busy");

    // A successful reschedule always reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.switched |-> out_data.status == STS_OK)
        else $error("switch with error status");

    // A created entry is never reported together with a switch or an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_index != 4'd0 |->
            out_data.status == STS_OK && !out_data.switched)
        else $error("new index on a failed or switching request");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);

`default_nettype wire
